// ----- src/rpe_pkg.sv -----
// Package for the r-permutation enumerator: item structs, action codes,
// register map and fixed widths. No dependencies.
`default_nettype none

package rpe_pkg;

	localparam int MAX_ITEMS_DEF = 8;
	localparam int LEVELS        = 8;
	localparam int LVL_W         = 3;
	localparam int VAL_W         = 32;
	localparam int CNT_W         = 4;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_NEXT   = 2'd2;

	// register index = paddr[ADDR_W-1:2]
	localparam logic [ADDR_W-3:0] REG_CHOOSE = '0;

	typedef struct packed {
		logic [1:0]              action;
		logic signed [VAL_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] elem_value;
		logic [LVL_W-1:0]        elem_position;
		logic                    last_elem;
		logic                    exhausted;
	} out_item_t;

endpackage

`default_nettype wire

// ----- src/r_permutation_enumerator.sv -----
// Top level of the r-permutation enumerator: sequencer, level list memory,
// cursor/length registers and APB register port. Uses rpe_pkg.
`default_nettype none

// Loads up to MAX_ITEMS values (action 1), clears them (action 0), and on each
// request (action 2) emits the next ordered choice of choose_count of them as
// that many element items, the final one marked last; past the end a request
// gives one exhausted item. All level lists live in one synchronous RAM with a
// single read and a single write port; each item of work is a walk over it.
// Clear and append are taken while idle. A request builds every level below the
// one whose cursor moved: per level it fetches the chosen value, searches for its
// first slot j, copies the rotated list and drains the write; advancing tries
// the levels from the deepest up; each element then takes a RAM read and an
// output load, and the receiver can hold it off.
// The RAM needs no clearing after reset.
module r_permutation_enumerator #(
	parameter int MAX_ITEMS = rpe_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire rpe_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output rpe_pkg::out_item_t                out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rpe_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [rpe_pkg::DATA_W-1:0]   pwdata,
	output logic [rpe_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import rpe_pkg::*;

	localparam int IW   = $clog2(MAX_ITEMS);
	localparam int LW   = $clog2(MAX_ITEMS + 1);
	localparam int SW   = LW + 1;
	localparam int AW   = LVL_W + IW;
	localparam int CMPW = (LW > CNT_W) ? LW : CNT_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ADV   = 4'd1;
	localparam logic [3:0] ST_VAL   = 4'd2;
	localparam logic [3:0] ST_WAITV = 4'd3;
	localparam logic [3:0] ST_SRCH  = 4'd4;
	localparam logic [3:0] ST_COPY  = 4'd5;
	localparam logic [3:0] ST_END   = 4'd6;
	localparam logic [3:0] ST_RD    = 4'd7;
	localparam logic [3:0] ST_WR    = 4'd8;
	localparam logic [3:0] ST_EXH   = 4'd9;

	localparam logic [1:0] RK_NONE  = 2'd0;
	localparam logic [1:0] RK_SRCH  = 2'd1;
	localparam logic [1:0] RK_COPY  = 2'd2;
	localparam logic [1:0] RK_PLAIN = 2'd3;

	logic [3:0]       state_q;
	logic [LVL_W-1:0] k_q, d_q, pos_q, lvl_sel;
	logic [LW-1:0]    idx_q;
	logic [IW-1:0]    o_q, j_q;
	logic [VAL_W-1:0] v_q;
	logic [CNT_W-1:0] choose_q;
	logic             started_q, finished_q;
	logic [LW-1:0]    lens_q [LEVELS];
	logic [LW-1:0]    curs_q [LEVELS];
	logic [LW-1:0]    sel_len, sel_cur, cur_inc;

	logic [VAL_W-1:0] mem [2**AW];
	logic             mem_re, mem_we;
	logic [AW-1:0]    mem_raddr, mem_waddr;
	logic [VAL_W-1:0] mem_wdata, rd_data_q;
	logic [1:0]       rd_kind_d, rd_kind_s1;
	logic [LW-1:0]    rd_tag_s1;
	logic [AW-1:0]    copy_waddr_d, copy_waddr_s1;

	logic [SW-1:0]    src_sum;
	logic [IW-1:0]    src_idx;
	logic             out_valid_q, slot_free, out_load, in_acc, cfg_we, run_bad;
	out_item_t        out_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign out_load  = slot_free && (state_q == ST_WR || state_q == ST_EXH);
	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CHOOSE);
	assign prdata    = (paddr[ADDR_W-1:2] == REG_CHOOSE) ?
		{{(DATA_W-CNT_W){1'b0}}, choose_q} : '0;

	assign run_bad = (choose_q == '0) || (choose_q > CNT_W'(LEVELS)) ||
		(CMPW'(choose_q) > CMPW'(lens_q[0]));

	always_comb begin
		case (state_q)
			ST_ADV:        lvl_sel = d_q;
			ST_RD, ST_WR:  lvl_sel = pos_q;
			default:       lvl_sel = k_q;
		endcase
	end

	assign sel_len = lens_q[lvl_sel];
	assign sel_cur = curs_q[lvl_sel];
	assign cur_inc = sel_cur + LW'(1);

	// rotated copy: entries after j, then entries before j
	assign src_sum = SW'(j_q) + SW'(o_q) + SW'(1);
	assign src_idx = (src_sum >= SW'(sel_len)) ? IW'(src_sum - SW'(sel_len)) : IW'(src_sum);

	always_comb begin
		mem_re       = 1'b0;
		mem_raddr    = '0;
		rd_kind_d    = RK_NONE;
		copy_waddr_d = '0;
		case (state_q)
			ST_VAL: begin
				mem_re    = 1'b1;
				mem_raddr = {k_q, sel_cur[IW-1:0]};
				rd_kind_d = RK_PLAIN;
			end
			ST_SRCH: begin
				if (idx_q < sel_len) begin
					mem_re    = 1'b1;
					mem_raddr = {k_q, idx_q[IW-1:0]};
					rd_kind_d = RK_SRCH;
				end
			end
			ST_COPY: begin
				mem_re       = 1'b1;
				mem_raddr    = {k_q, src_idx};
				rd_kind_d    = RK_COPY;
				copy_waddr_d = {k_q + LVL_W'(1), o_q};
			end
			ST_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {pos_q, sel_cur[IW-1:0]};
				rd_kind_d = RK_PLAIN;
			end
			default: ;
		endcase
	end

	// single write port: appends while idle, list copies while building
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = copy_waddr_s1;
		mem_wdata = rd_data_q;
		if (rd_kind_s1 == RK_COPY) begin
			mem_we = 1'b1;
		end else if (in_acc && in_data.action == ACT_APPEND &&
				lens_q[0] < LW'(MAX_ITEMS)) begin
			mem_we    = 1'b1;
			mem_waddr = {LVL_W'(0), lens_q[0][IW-1:0]};
			mem_wdata = in_data.item_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_kind_s1 <= RK_NONE;
		end else begin
			rd_kind_s1 <= rd_kind_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_s1     <= idx_q;
		copy_waddr_s1 <= copy_waddr_d;
		if (state_q == ST_WAITV) begin
			v_q <= rd_data_q;
		end
		if (out_load) begin
			if (state_q == ST_EXH) begin
				out_q.elem_value    <= '0;
				out_q.elem_position <= '0;
				out_q.last_elem     <= 1'b1;
				out_q.exhausted     <= 1'b1;
			end else begin
				out_q.elem_value    <= $signed(rd_data_q);
				out_q.elem_position <= pos_q;
				out_q.last_elem     <= (CNT_W'(pos_q) + CNT_W'(1) == choose_q);
				out_q.exhausted     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			d_q         <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			o_q         <= '0;
			j_q         <= '0;
			choose_q    <= CNT_W'(1);
			started_q   <= 1'b0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
			lens_q      <= '{default: '0};
			curs_q      <= '{default: '0};
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_data.action)
							ACT_CLEAR: begin
								lens_q[0]  <= '0;
								curs_q[0]  <= '0;
								started_q  <= 1'b0;
								finished_q <= 1'b0;
							end
							ACT_APPEND: begin
								if (lens_q[0] < LW'(MAX_ITEMS)) begin
									lens_q[0] <= lens_q[0] + LW'(1);
								end
								started_q  <= 1'b0;
								finished_q <= 1'b0;
							end
							ACT_NEXT: begin
								if (finished_q) begin
									state_q <= ST_EXH;
								end else if (!started_q) begin
									if (run_bad) begin
										state_q <= ST_EXH;
									end else begin
										started_q <= 1'b1;
										curs_q[0] <= '0;
										k_q       <= '0;
										pos_q     <= '0;
										state_q   <= (choose_q > CNT_W'(1)) ? ST_VAL : ST_RD;
									end
								end else begin
									d_q     <= LVL_W'(choose_q - CNT_W'(1));
									state_q <= ST_ADV;
								end
							end
							default: ;
						endcase
					end
				end
				ST_ADV: begin
					// step the deepest level that still has a candidate
					curs_q[d_q] <= cur_inc;
					if (cur_inc < sel_len) begin
						k_q     <= d_q;
						pos_q   <= '0;
						state_q <= (CNT_W'(d_q) + CNT_W'(1) < choose_q) ? ST_VAL : ST_RD;
					end else if (d_q == '0) begin
						state_q <= ST_EXH;
					end else begin
						d_q <= d_q - LVL_W'(1);
					end
				end
				ST_VAL: begin
					state_q <= ST_WAITV;
				end
				ST_WAITV: begin
					idx_q   <= '0;
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (idx_q < sel_len) begin
						idx_q <= idx_q + LW'(1);
					end
					if (rd_kind_s1 == RK_SRCH && rd_data_q == v_q) begin
						j_q     <= rd_tag_s1[IW-1:0];
						o_q     <= '0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (LW'(o_q) + LW'(2) >= sel_len) begin
						lens_q[k_q + LVL_W'(1)] <= sel_len - LW'(1);
						curs_q[k_q + LVL_W'(1)] <= '0;
						state_q                 <= ST_END;
					end else begin
						o_q <= o_q + IW'(1);
					end
				end
				ST_END: begin
					// last copy write lands this cycle
					k_q     <= k_q + LVL_W'(1);
					pos_q   <= '0;
					state_q <= (CNT_W'(k_q) + CNT_W'(2) < choose_q) ? ST_VAL : ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (slot_free) begin
						if (CNT_W'(pos_q) + CNT_W'(1) >= choose_q) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + LVL_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_EXH: begin
					if (slot_free) begin
						finished_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				choose_q   <= pwdata[CNT_W-1:0];
				started_q  <= 1'b0;
				finished_q <= 1'b0;
			end
		end
	end

	a_exh_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.exhausted) |->
		(out_data.last_elem && out_data.elem_value == '0 && out_data.elem_position == '0))
		else $error("exhausted item with nonzero fields");

	a_srch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (idx_q <= sel_len))
		else $error("search index ran past list length");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD || $past(state_q) == ST_WR))
		else $error("element output without RAM read");

	a_copy_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_kind_s1 == RK_COPY) |-> (state_q == ST_COPY || state_q == ST_END))
		else $error("list copy write outside build");

endmodule

`default_nettype wire
